// File: hdl/adrc_pkg.sv
// ----------------------------------------------------------------------------
// adrc_pkg
// Shared types, constants and tables of the dynamic range compressor.
// ----------------------------------------------------------------------------
package adrc_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned AddrW = 5;
  localparam int unsigned MulW  = 33;

  localparam logic [15:0] ThresholdRst = 16'd0;
  localparam logic [15:0] SlopeRst     = 16'd0;
  localparam logic [15:0] AttackRst    = 16'd63000;
  localparam logic [15:0] ReleaseRst   = 16'd65200;
  localparam logic [15:0] MakeupRst    = 16'd4096;

  localparam logic [15:0] Log2ToDbQ12 = 16'd24660;
  localparam logic [15:0] DbToLog2Q16 = 16'd10885;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_SLOPE     = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_MAKEUP    = 3'd4
  } reg_idx_e;

  typedef logic [31:0] exp_tbl_t [16];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    b   = 64'd1 << 62;
    rem = v;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-(k+1)) in Q.30, chained square roots
  function automatic exp_tbl_t gen_exp_tbl();
    exp_tbl_t    tbl;
    logic [63:0] t;
    t = isqrt64(64'd1 << 61);
    for (int k = 0; k < 16; k++) begin
      tbl[k] = t[31:0];
      t      = isqrt64(t << 30);
    end
    return tbl;
  endfunction

  localparam exp_tbl_t ExpTbl = gen_exp_tbl();

endpackage

// File: hdl/audio_dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor
// Feed-forward compressor: log2 level, dB envelope, exp2 gain, output gain.
// ----------------------------------------------------------------------------
// No new sample is accepted until the current one has left the last step.
// A single 33x33 signed multiplier is shared by all steps but the threshold
// compare and the final gain shift:
//   - 12 squaring passes for the log2 fraction
//   - 16 table passes for the exp2 mantissa
//   - one pass each for dB scaling, envelope, gain and exponent
//   - two passes for the output product
// The input is ready again once the result is loaded into the output register,
// which holds it until taken. While an earlier result still waits there, the
// last step stalls. The user must write registers over APB only while idle;
// the block does not enforce this.
module audio_dynamic_range_compressor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // [15:0] sample_in
  input  logic                         s_axis_tlast,   // block_last
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [15:0] sample_out
  output logic                         m_axis_tlast,   // last
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adrc_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQR, ST_LDB, ST_OVR, ST_ENV, ST_GDB,
    ST_EXP, ST_MANT, ST_GAIN, ST_XM, ST_YM
  } state_e;

  state_e state_q;

  logic [15:0] thr_q, slope_q, att_q, rel_q, mg_q;
  logic [14:0] env_q;

  logic signed [15:0] x_q;
  logic               last_q;
  logic [15:0]        m_q;
  logic [3:0]         msb_q;
  logic               zero_q;
  logic [11:0]        frac_q;
  logic [3:0]         cnt_q;
  logic signed [16:0] lvl_q;
  logic [14:0]        over_q;
  logic signed [16:0] g_q;
  logic signed [23:0] e_q;
  logic [31:0]        mant_q;
  logic [31:0]        gain_q;
  logic signed [32:0] xm_q;
  logic [15:0]        out_q;
  logic               out_last_q;
  logic               out_vld_q;
  logic               out_load;

  // shared multiplier
  logic signed [adrc_pkg::MulW-1:0]   mul_a, mul_b;
  logic signed [2*adrc_pkg::MulW-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [16:0] l2;
  logic signed [16:0] env_diff;
  logic [15:0]        coef;
  assign l2       = $signed({13'd0, msb_q} - 17'sd15) * 17'sd4096
                    + $signed({5'd0, frac_q});
  assign env_diff = $signed({2'b0, env_q}) - $signed({2'b0, over_q});
  assign coef     = (over_q > env_q) ? att_q : rel_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQR:  begin mul_a = $signed({17'd0, m_q}); mul_b = $signed({17'd0, m_q}); end
      ST_LDB:  begin mul_a = 33'(l2); mul_b = $signed({17'd0, adrc_pkg::Log2ToDbQ12}); end
      ST_ENV:  begin mul_a = 33'(env_diff); mul_b = $signed({17'd0, coef}); end
      ST_GDB:  begin mul_a = $signed({18'd0, env_q}); mul_b = 33'($signed(slope_q)); end
      ST_EXP:  begin mul_a = 33'(g_q); mul_b = $signed({17'd0, adrc_pkg::DbToLog2Q16}); end
      ST_MANT: begin
        mul_a = $signed({1'b0, mant_q});
        mul_b = $signed({1'b0, adrc_pkg::ExpTbl[cnt_q]});
      end
      ST_XM:   begin mul_a = 33'(x_q); mul_b = $signed({17'd0, mg_q}); end
      ST_YM:   begin mul_a = xm_q; mul_b = $signed({1'b0, gain_q}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // input rectify and normalize
  logic [15:0] r_in;
  logic [3:0]  msb_in;
  assign r_in = s_axis_tdata[15] ? 16'(-s_axis_tdata) : s_axis_tdata;
  always_comb begin
    msb_in = '0;
    for (int i = 0; i < 16; i++) if (r_in[i]) msb_in = 4'(i);
  end

  // per-step datapath
  logic [16:0]        sq;
  logic signed [65:0] t_ldb, t_env, t_gdb, t_exp, t_mant, t_ym;
  logic signed [17:0] over_raw;
  logic signed [18:0] env_raw;
  logic signed [16:0] g_raw;
  logic signed [7:0]  n_exp;
  logic [7:0]         sh;
  logic signed [23:0] y_raw;

  assign sq       = mul_p[31:15];
  assign t_ldb    = mul_p + 66'sd32768;
  assign over_raw = 18'(lvl_q) - 18'($signed(thr_q));
  assign t_env    = mul_p + 66'sd32768;
  assign env_raw  = $signed({4'd0, over_q}) + 19'($signed(t_env[33:16]));
  assign t_gdb    = mul_p + 66'sd16384;
  assign g_raw    = t_gdb[31:15];
  assign t_exp    = mul_p + 66'sd128;
  assign t_mant   = mul_p + (66'sd1 <<< 29);
  assign n_exp    = e_q[23:16];
  assign sh       = 8'(-n_exp);
  assign t_ym     = mul_p + (66'sd1 <<< 41);
  assign y_raw    = t_ym[65:42];

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      adrc_pkg::REG_THRESHOLD: prdata = {16'd0, thr_q};
      adrc_pkg::REG_SLOPE:     prdata = {16'd0, slope_q};
      adrc_pkg::REG_ATTACK:    prdata = {16'd0, att_q};
      adrc_pkg::REG_RELEASE:   prdata = {16'd0, rel_q};
      adrc_pkg::REG_MAKEUP:    prdata = {16'd0, mg_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= adrc_pkg::ThresholdRst;
      slope_q <= adrc_pkg::SlopeRst;
      att_q   <= adrc_pkg::AttackRst;
      rel_q   <= adrc_pkg::ReleaseRst;
      mg_q    <= adrc_pkg::MakeupRst;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        adrc_pkg::REG_THRESHOLD: thr_q   <= pwdata[15:0];
        adrc_pkg::REG_SLOPE:     slope_q <= pwdata[15:0];
        adrc_pkg::REG_ATTACK:    att_q   <= pwdata[15:0];
        adrc_pkg::REG_RELEASE:   rel_q   <= pwdata[15:0];
        adrc_pkg::REG_MAKEUP:    mg_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign out_load = (state_q == ST_YM) && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      env_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_load)           out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid) begin
          x_q     <= s_axis_tdata;
          last_q  <= s_axis_tlast;
          m_q     <= r_in << (4'd15 - msb_in);
          msb_q   <= msb_in;
          zero_q  <= (r_in == '0);
          frac_q  <= '0;
          cnt_q   <= '0;
          state_q <= ST_SQR;
        end
        ST_SQR: begin
          frac_q <= {frac_q[10:0], sq[16]};
          m_q    <= sq[16] ? sq[16:1] : sq[15:0];
          cnt_q  <= cnt_q + 4'd1;
          if (cnt_q == 4'd11) state_q <= ST_LDB;
        end
        ST_LDB: begin
          lvl_q   <= zero_q ? -17'sd32768 : t_ldb[32:16];
          state_q <= ST_OVR;
        end
        ST_OVR: begin
          if (over_raw < 0)             over_q <= '0;
          else if (over_raw > 18'sd32767) over_q <= 15'h7fff;
          else                          over_q <= over_raw[14:0];
          state_q <= ST_ENV;
        end
        ST_ENV: begin
          if (env_raw < 0)              env_q <= '0;
          else if (env_raw > 19'sd32767) env_q <= 15'h7fff;
          else                          env_q <= env_raw[14:0];
          state_q <= ST_GDB;
        end
        ST_GDB: begin
          g_q     <= (g_raw > 0) ? 17'sd0 : g_raw;
          state_q <= ST_EXP;
        end
        ST_EXP: begin
          e_q     <= t_exp[31:8];
          mant_q  <= 32'd1 << 30;
          cnt_q   <= '0;
          state_q <= ST_MANT;
        end
        ST_MANT: begin
          if (e_q[4'd15 - cnt_q]) mant_q <= t_mant[61:30];
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) state_q <= ST_GAIN;
        end
        ST_GAIN: begin
          gain_q  <= (sh >= 8'd32) ? 32'd0 : (mant_q >> sh[4:0]);
          state_q <= ST_XM;
        end
        ST_XM: begin
          xm_q    <= mul_p[32:0];
          state_q <= ST_YM;
        end
        ST_YM: if (out_load) begin
          if (y_raw > 24'sd32767)       out_q <= 16'h7fff;
          else if (y_raw < -24'sd32768) out_q <= 16'h8000;
          else                          out_q <= y_raw[15:0];
          out_last_q <= last_q;
          state_q    <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while sample in flight");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_XM |-> gain_q <= 32'h4000_0000)
    else $error("linear gain above unity");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_YM && (!out_vld_q || m_axis_tready) |=> out_vld_q && s_axis_tready)
    else $error("result not loaded at end of sequence");

endmodule

// File: tb/tb_audio_dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// tb_audio_dynamic_range_compressor
// Streams signed samples through the compressor under several register
// settings and random handshake idling, and checks every output transaction
// against a bit-exact prediction of the log/envelope/exp gain path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_audio_dynamic_range_compressor;

  localparam int ClkPeriod = 12;
  localparam int DrainCycles = 60;
  localparam int BadRegIdx = 5;
  localparam int AddrW = adrc_pkg::AddrW;

  typedef struct {
    logic [15:0] sample;
    logic        last;
  } out_item_t;

  class compressor_scoreboard;
    logic signed [15:0] thr;
    logic signed [15:0] slp;
    logic [15:0]        att;
    logic [15:0]        rel;
    logic [15:0]        mkp;
    logic [14:0]        env;
    logic [31:0]        pow_tbl[16];
    out_item_t          pending[$];

    function new();
      longint unsigned t;
      t = root(64'd1 << 61);
      for (int k = 0; k < 16; k++) begin
        pow_tbl[k] = t[31:0];
        t = root(t << 30);
      end
      thr = 16'sd0;
      slp = 16'sd0;
      att = 16'd63000;
      rel = 16'd65200;
      mkp = 16'd4096;
      env = '0;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function void set_reg(int idx, logic [15:0] v);
      case (idx)
        adrc_pkg::REG_THRESHOLD: thr = v;
        adrc_pkg::REG_SLOPE:     slp = v;
        adrc_pkg::REG_ATTACK:    att = v;
        adrc_pkg::REG_RELEASE:   rel = v;
        adrc_pkg::REG_MAKEUP:    mkp = v;
        default: ;
      endcase
    endfunction

    function longint level_db(longint x);
      longint unsigned r;
      longint unsigned m;
      longint          frac;
      longint          l2;
      int              msb;
      r = (x < 0) ? -x : x;
      if (r == 0) return -32768;
      msb = 0;
      for (int i = 0; i < 16; i++) if (r[i]) msb = i;
      m = r << (15 - msb);
      frac = 0;
      for (int i = 0; i < 12; i++) begin
        m = (m * m) >> 15;
        frac = frac << 1;
        if (m >= 65536) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      l2 = (longint'(msb) - 15) * 4096 + frac;
      return (l2 * 24660 + 32768) >>> 16;
    endfunction

    function longint gain_q30(longint g);
      longint          e;
      longint          n;
      longint unsigned f;
      longint unsigned m;
      e = (g * 10885 + 128) >>> 8;
      n = e >>> 16;
      f = e & 64'hFFFF;
      m = 64'd1 << 30;
      for (int k = 0; k < 16; k++)
        if (f[15-k]) m = (m * pow_tbl[k] + (64'd1 << 29)) >> 30;
      if (-n >= 63) return 0;
      return longint'(m >> (-n));
    endfunction

    function void note_input(logic [15:0] s, logic l);
      longint    x;
      longint    over;
      longint    e;
      longint    coef;
      longint    g;
      longint    y;
      out_item_t item;
      x = longint'($signed(s));
      over = level_db(x) - longint'(thr);
      if (over < 0) over = 0;
      if (over > 32767) over = 32767;
      e = longint'(env);
      coef = (over > e) ? longint'(att) : longint'(rel);
      e = over + ((coef * (e - over) + 32768) >>> 16);
      if (e < 0) e = 0;
      if (e > 32767) e = 32767;
      env = e[14:0];
      g = (e * longint'(slp) + 16384) >>> 15;
      if (g > 0) g = 0;
      y = (x * longint'(mkp) * gain_q30(g) + (64'sd1 <<< 41)) >>> 42;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      item.sample = y[15:0];
      item.last = l;
      pending.push_back(item);
    endfunction

    function string check_output(logic [15:0] s, logic l);
      out_item_t want;
      if (pending.size() == 0)
        return $sformatf("unexpected output sample %0d", $signed(s));
      want = pending.pop_front();
      if (s !== want.sample)
        return $sformatf("sample_out %0d, expected %0d", $signed(s), $signed(want.sample));
      if (l !== want.last)
        return $sformatf("last %0b, expected %0b", l, want.last);
      return "";
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] sample_in
  logic        s_axis_tlast;   // block_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] sample_out
  logic        m_axis_tlast;   // last
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  compressor_scoreboard sb;
  int errors;
  int send_idle;
  int recv_idle;

  audio_dynamic_range_compressor u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic report(string msg);
    errors++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    string msg;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        msg = sb.check_output(m_axis_tdata, m_axis_tlast);
        if (msg != "") report(msg);
      end
    end
  end

  task automatic write_reg(int idx, logic [15:0] v);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = AddrW'(idx * 4);
    pwdata = {16'd0, v};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_all(logic [15:0] t, logic [15:0] s, logic [15:0] a,
                         logic [15:0] r, logic [15:0] g);
    write_reg(adrc_pkg::REG_THRESHOLD, t);
    write_reg(adrc_pkg::REG_SLOPE, s);
    write_reg(adrc_pkg::REG_ATTACK, a);
    write_reg(adrc_pkg::REG_RELEASE, r);
    write_reg(adrc_pkg::REG_MAKEUP, g);
  endtask

  task automatic send(logic [15:0] d, logic l);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = d;
    s_axis_tlast = l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'($urandom_range(65535));
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(255))
                                  : 16'h8000 + 16'($urandom_range(255));
      3: return 16'($urandom_range(65535)) >>> $urandom_range(15);
      default: return 16'($urandom_range(65535)) >> $urandom_range(15);
    endcase
  endfunction

  task automatic random_burst(int n);
    int amp;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) amp = $urandom_range(15);
      if ($urandom_range(3) == 0) send(rand_sample(), $urandom_range(7) == 0);
      else send(16'($urandom_range(65535)) >>> amp, $urandom_range(7) == 0);
    end
  endtask

  task automatic random_config();
    set_all(16'(-$signed($urandom_range(24576))), 16'(-$signed($urandom_range(32768))),
            $urandom_range(1) ? 16'($urandom_range(65535)) : 16'(65535 - $urandom_range(4000)),
            $urandom_range(1) ? 16'($urandom_range(65535)) : 16'(65535 - $urandom_range(2000)),
            $urandom_range(1) ? 16'($urandom_range(65535)) : 16'(3000 + $urandom_range(4000)));
  endtask

  initial begin
    logic [15:0] pts[$];
    sb = new();
    errors = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults after reset; silence, full-scale and bit-walking samples
    pts = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h4000,
            16'hC000, 16'h5555, 16'hAAAA, 16'h0100, 16'hFF00, 16'h0000};
    foreach (pts[i]) send(pts[i], i[0]);
    go_idle();

    // extremes: low threshold, hardest slope, zero poles, max gain
    set_all(16'h A000, 16'h8000, 16'd0, 16'd0, 16'hFFFF);
    write_reg(BadRegIdx, 16'h1234);
    pts = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'h7FFF, 16'h0003};
    foreach (pts[i]) send(pts[i], 1'b1);
    go_idle();

    // positive slope gets clamped, zero makeup gain, max poles
    set_all(16'h0000, 16'h4000, 16'hFFFF, 16'hFFFF, 16'h0000);
    pts = '{16'h7FFF, 16'h8000, 16'h1234};
    foreach (pts[i]) send(pts[i], 1'b0);
    go_idle();
    set_all(16'hF400, 16'h7FFF, 16'd100, 16'd200, 16'd4096);
    pts = '{16'h7FFF, 16'h0010, 16'h8001};
    foreach (pts[i]) send(pts[i], 1'b1);
    go_idle();

    send_idle = 35;
    recv_idle = 81;
    random_config();
    random_burst(250);
    go_idle();
    send_idle = 0;
    random_burst(10);
    go_idle();
    send_idle = 35;
    random_config();
    random_burst(250);
    go_idle();

    send_idle = 81;
    recv_idle = 35;
    random_config();
    random_burst(250);
    go_idle();
    random_config();
    random_burst(220);
    go_idle();

    send_idle = 0;
    recv_idle = 0;
    random_config();
    random_burst(250);
    go_idle();
    set_all(16'h0000, 16'h0000, 16'd63000, 16'd65200, 16'd4096);
    random_burst(220);
    go_idle();

    if (sb.pending.size() != 0) report("expected outputs never arrived");
    if (errors == 0) begin
      $display("audio_dynamic_range_compressor test passed");
    end else begin
      $display("audio_dynamic_range_compressor test failed");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("audio_dynamic_range_compressor test failed");
    $finish;
  end

endmodule
